>>> rtl/lcdseq_pkg.sv
`default_nettype none
package lcdseq_pkg;

   localparam int UPC_WIDTH = 5;
   typedef logic [UPC_WIDTH-1:0] upc_type;

   typedef logic [2:0] kind_type;
   localparam kind_type KIND_INIT   = 3'd0;
   localparam kind_type KIND_CMD    = 3'd1;
   localparam kind_type KIND_DATA   = 3'd2;
   localparam kind_type KIND_CLEAR  = 3'd3;
   localparam kind_type KIND_CURSOR = 3'd4;

   // Microcode entry points and jump targets.
   localparam upc_type UPC_INIT      = 5'd0;
   localparam upc_type UPC_WAKE4     = 5'd1;
   localparam upc_type UPC_FUNC4     = 5'd5;
   localparam upc_type UPC_WAKE8     = 5'd6;
   localparam upc_type UPC_FUNC8     = 5'd9;
   localparam upc_type UPC_TAIL      = 5'd10;
   localparam upc_type UPC_DISP_ON   = 5'd10;
   localparam upc_type UPC_INIT_CLR  = 5'd11;
   localparam upc_type UPC_ENTRY     = 5'd12;
   localparam upc_type UPC_CMD       = 5'd13;
   localparam upc_type UPC_DATA      = 5'd14;
   localparam upc_type UPC_CLEAR     = 5'd15;
   localparam upc_type UPC_CURSOR    = 5'd16;

   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_ENTRY      = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
   localparam logic [7:0] CMD_FUNC_8BIT  = 8'h38;
   localparam logic [7:0] WAKE_NIBBLE    = 8'h03;
   localparam logic [7:0] WAKE_4BIT      = 8'h02;

   localparam logic [2:0] CSR_EIGHT_BIT_BUS = 3'd0;

   typedef enum logic [1:0] {
      SRC_CONST,
      SRC_BYTE,
      SRC_CURSOR
   } src_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_IF_EIGHT
   } jump_type;

   typedef struct packed {
      src_type    src;
      logic       split;
      logic       rs;
      logic       strobe;
      logic [7:0] data;
      logic [7:0] wait_ms;
      logic       last;
      jump_type   jump;
      upc_type    target;
   } uword_type;

   typedef struct packed {
      logic       rs;
      logic [7:0] bus;
      logic       strobe;
      logic [7:0] wait_ms;
      logic       last;
      logic       advance;
   } xfer_type;

   function automatic uword_type uw(src_type src, logic split, logic rs, logic strobe,
                                    logic [7:0] data, logic [7:0] wait_ms, logic last,
                                    jump_type jump, upc_type target);
      uword_type w;
      w.src     = src;
      w.split   = split;
      w.rs      = rs;
      w.strobe  = strobe;
      w.data    = data;
      w.wait_ms = wait_ms;
      w.last    = last;
      w.jump    = jump;
      w.target  = target;
      return w;
   endfunction

   function automatic logic kind_valid(kind_type kind);
      return (kind == KIND_INIT) || (kind == KIND_CMD) || (kind == KIND_DATA) ||
             (kind == KIND_CLEAR) || (kind == KIND_CURSOR);
   endfunction

   function automatic upc_type kind_entry(kind_type kind);
      upc_type e;
      case (kind)
         KIND_INIT:   e = UPC_INIT;
         KIND_CMD:    e = UPC_CMD;
         KIND_DATA:   e = UPC_DATA;
         KIND_CLEAR:  e = UPC_CLEAR;
         KIND_CURSOR: e = UPC_CURSOR;
         default:     e = UPC_INIT;
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

>>> rtl/lcdseq_ucode_rom.sv
`default_nettype none
module lcdseq_ucode_rom #(
   parameter int POWER_ON_WAIT_MS = 50
) (
   input  lcdseq_pkg::upc_type   addr,
   output lcdseq_pkg::uword_type word
);
   import lcdseq_pkg::*;

   localparam logic [7:0] PowerWait = 8'(POWER_ON_WAIT_MS);

   always_comb begin
      case (addr)
         // Initialize: power-on wait, then branch on bus width.
         5'd0:  word = uw(SRC_CONST, 1'b0, 1'b0, 1'b0, 8'h00, PowerWait, 1'b0,
                          JMP_IF_EIGHT, UPC_WAKE8);
         5'd1:  word = uw(SRC_CONST, 1'b0, 1'b0, 1'b1, WAKE_NIBBLE, 8'd6, 1'b0,
                          JMP_NEXT, UPC_INIT);
         5'd2:  word = uw(SRC_CONST, 1'b0, 1'b0, 1'b1, WAKE_NIBBLE, 8'd6, 1'b0,
                          JMP_NEXT, UPC_INIT);
         5'd3:  word = uw(SRC_CONST, 1'b0, 1'b0, 1'b1, WAKE_NIBBLE, 8'd3, 1'b0,
                          JMP_NEXT, UPC_INIT);
         5'd4:  word = uw(SRC_CONST, 1'b0, 1'b0, 1'b1, WAKE_4BIT, 8'd3, 1'b0,
                          JMP_NEXT, UPC_INIT);
         5'd5:  word = uw(SRC_CONST, 1'b1, 1'b0, 1'b1, CMD_FUNC_4BIT, 8'd1, 1'b0,
                          JMP_ALWAYS, UPC_TAIL);
         5'd6:  word = uw(SRC_CONST, 1'b0, 1'b0, 1'b1, CMD_FUNC_8BIT, 8'd6, 1'b0,
                          JMP_NEXT, UPC_INIT);
         5'd7:  word = uw(SRC_CONST, 1'b0, 1'b0, 1'b1, CMD_FUNC_8BIT, 8'd6, 1'b0,
                          JMP_NEXT, UPC_INIT);
         5'd8:  word = uw(SRC_CONST, 1'b0, 1'b0, 1'b1, CMD_FUNC_8BIT, 8'd6, 1'b0,
                          JMP_NEXT, UPC_INIT);
         5'd9:  word = uw(SRC_CONST, 1'b1, 1'b0, 1'b1, CMD_FUNC_8BIT, 8'd1, 1'b0,
                          JMP_NEXT, UPC_INIT);
         5'd10: word = uw(SRC_CONST, 1'b1, 1'b0, 1'b1, CMD_DISPLAY_ON, 8'd3, 1'b0,
                          JMP_NEXT, UPC_INIT);
         5'd11: word = uw(SRC_CONST, 1'b1, 1'b0, 1'b1, CMD_CLEAR, 8'd6, 1'b0,
                          JMP_NEXT, UPC_INIT);
         5'd12: word = uw(SRC_CONST, 1'b1, 1'b0, 1'b1, CMD_ENTRY, 8'd3, 1'b1,
                          JMP_NEXT, UPC_INIT);
         // Single-byte requests.
         5'd13: word = uw(SRC_BYTE, 1'b1, 1'b0, 1'b1, 8'h00, 8'd1, 1'b1,
                          JMP_NEXT, UPC_INIT);
         5'd14: word = uw(SRC_BYTE, 1'b1, 1'b1, 1'b1, 8'h00, 8'd1, 1'b1,
                          JMP_NEXT, UPC_INIT);
         5'd15: word = uw(SRC_CONST, 1'b1, 1'b0, 1'b1, CMD_CLEAR, 8'd6, 1'b1,
                          JMP_NEXT, UPC_INIT);
         5'd16: word = uw(SRC_CURSOR, 1'b1, 1'b0, 1'b1, 8'h00, 8'd1, 1'b1,
                          JMP_NEXT, UPC_INIT);
         default: word = uw(SRC_CONST, 1'b0, 1'b0, 1'b0, 8'h00, 8'd0, 1'b1,
                            JMP_NEXT, UPC_INIT);
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/lcdseq_datapath.sv
`default_nettype none
module lcdseq_datapath (
   input  lcdseq_pkg::uword_type word,
   input  logic                  phase,
   input  logic                  eight_bit_bus,
   input  logic [7:0]            byte_value,
   input  logic [5:0]            column,
   input  logic                  row,
   output lcdseq_pkg::xfer_type  xfer
);
   import lcdseq_pkg::*;

   logic [7:0] byte_sel;
   logic       nibble_mode;

   always_comb begin
      case (word.src)
         SRC_CONST:  byte_sel = word.data;
         SRC_BYTE:   byte_sel = byte_value;
         // Set-address command; column is below 0x40, so the row offset is a bit.
         SRC_CURSOR: byte_sel = {1'b1, row, column};
         default:    byte_sel = word.data;
      endcase

      nibble_mode = word.split && !eight_bit_bus;

      xfer.rs     = word.rs;
      xfer.strobe = word.strobe;
      if (nibble_mode && !phase) begin
         xfer.bus     = {4'h0, byte_sel[7:4]};
         xfer.wait_ms = 8'd1;
         xfer.last    = 1'b0;
         xfer.advance = 1'b0;
      end else if (nibble_mode) begin
         xfer.bus     = {4'h0, byte_sel[3:0]};
         xfer.wait_ms = word.wait_ms;
         xfer.last    = word.last;
         xfer.advance = 1'b1;
      end else begin
         xfer.bus     = byte_sel;
         xfer.wait_ms = word.wait_ms;
         xfer.last    = word.last;
         xfer.advance = 1'b1;
      end
   end

endmodule
`default_nettype wire

>>> rtl/char_lcd_bus_sequencer_unit.sv
`default_nettype none
// Character LCD bus sequencer. Each accepted request transaction is expanded into
// its run of bus transfers by a microcode step counter that walks a read-only
// control table, one transfer per clock while the result side is ready; in 4-bit
// mode a byte step is issued twice (high nibble, then low nibble). Initialize
// produces 13 transfers in 4-bit mode and 8 in 8-bit mode, command, data, clear
// and set cursor produce 2 (4-bit) or 1 (8-bit), and unused kinds are accepted
// and dropped with no transfer. A request keeps the block busy from its acceptance
// until its last transfer is loaded into the output register, and a stalled result
// side holds the sequence; no new request is accepted before then.
module char_lcd_bus_sequencer_unit #(
   parameter int POWER_ON_WAIT_MS = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_byte_value,
   input  logic [5:0]  req_column,
   input  logic        req_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_register_select,
   output logic [7:0]  rsp_bus_value,
   output logic        rsp_strobe_res,
   output logic [7:0]  rsp_wait_ms,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lcdseq_pkg::*;

   logic       eight_ff, eight_in;
   logic       busy_ff, busy_in;
   upc_type    upc_ff, upc_in;
   logic       phase_ff, phase_in;
   logic [7:0] byte_ff, byte_in;
   logic [5:0] column_ff, column_in;
   logic       row_ff, row_in;
   logic       out_valid_ff, out_valid_in;
   xfer_type   out_ff, out_in;

   uword_type  word;
   xfer_type   xfer;
   logic       fire;
   logic       req_take;
   upc_type    upc_next;

   lcdseq_ucode_rom #(
      .POWER_ON_WAIT_MS(POWER_ON_WAIT_MS)
   ) u_rom (
      .addr(upc_ff),
      .word(word)
   );

   lcdseq_datapath u_dp (
      .word(word),
      .phase(phase_ff),
      .eight_bit_bus(eight_ff),
      .byte_value(byte_ff),
      .column(column_ff),
      .row(row_ff),
      .xfer(xfer)
   );

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_EIGHT_BIT_BUS) ? {31'b0, eight_ff} : 32'b0;

   assign req_ready = !busy_ff;
   assign req_take  = req_valid && req_ready;
   assign fire      = busy_ff && (!out_valid_ff || rsp_ready);

   assign rsp_valid           = out_valid_ff;
   assign rsp_register_select = out_ff.rs;
   assign rsp_bus_value       = out_ff.bus;
   assign rsp_strobe_res      = out_ff.strobe;
   assign rsp_wait_ms         = out_ff.wait_ms;
   assign rsp_last            = out_ff.last;

   always_comb begin
      case (word.jump)
         JMP_NEXT:     upc_next = upc_ff + 1'b1;
         JMP_ALWAYS:   upc_next = word.target;
         JMP_IF_EIGHT: upc_next = eight_ff ? word.target : upc_ff + 1'b1;
         default:      upc_next = upc_ff + 1'b1;
      endcase

      eight_in = eight_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_EIGHT_BIT_BUS) begin
         eight_in = csr_pwdata[0];
      end

      busy_in      = busy_ff;
      upc_in       = upc_ff;
      phase_in     = phase_ff;
      byte_in      = byte_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (req_take) begin
         busy_in   = kind_valid(req_kind);
         upc_in    = kind_entry(req_kind);
         phase_in  = 1'b0;
         byte_in   = req_byte_value;
         column_in = req_column;
         row_in    = req_row;
      end

      if (fire) begin
         out_in       = xfer;
         out_valid_in = 1'b1;
         if (xfer.advance) begin
            phase_in = 1'b0;
            upc_in   = upc_next;
            if (xfer.last) begin
               busy_in = 1'b0;
            end
         end else begin
            phase_in = 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eight_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         upc_ff       <= UPC_INIT;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         eight_ff     <= eight_in;
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      column_ff <= column_in;
      row_ff    <= row_in;
      out_ff    <= out_in;
   end

endmodule
`default_nettype wire

>>> rtl/lcdseq_checker.sv
`default_nettype none
module lcdseq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_register_select,
   input logic [7:0]  rsp_bus_value,
   input logic        rsp_strobe_res,
   input logic [7:0]  rsp_wait_ms,
   input logic        rsp_last
);
   import lcdseq_pkg::*;

   // A stalled transfer must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bus_value) &&
      $stable(rsp_wait_ms) && $stable(rsp_last) && $stable(rsp_register_select))
      else $error("stalled transfer changed");

   // A recognized request keeps the block busy for at least one transfer.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_INIT || req_kind == KIND_CMD ||
      req_kind == KIND_DATA || req_kind == KIND_CLEAR || req_kind == KIND_CURSOR)
      |=> !req_ready)
      else $error("request accepted without starting a sequence");

   // The only pure wait is the power-on wait, which is never last.
   a_pure_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_strobe_res |-> !rsp_register_select &&
      rsp_bus_value == 8'h00 && !rsp_last)
      else $error("malformed pure wait");

   // Data writes are always strobed.
   a_data_strobed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_register_select |-> rsp_strobe_res)
      else $error("data transfer without strobe");

endmodule

bind char_lcd_bus_sequencer_unit lcdseq_checker u_lcdseq_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_kind(req_kind),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_register_select(rsp_register_select),
   .rsp_bus_value(rsp_bus_value),
   .rsp_strobe_res(rsp_strobe_res),
   .rsp_wait_ms(rsp_wait_ms),
   .rsp_last(rsp_last)
);
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import lcdseq_pkg::*;

   localparam int POWER_ON_MS    = 50;
   localparam int RANDOM_TARGET  = 180;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic [7:0] SETTLE_MS = 8'd1;
   localparam logic [7:0] SHORT_MS  = 8'd3;
   localparam logic [7:0] LONG_MS   = 8'd6;

   localparam logic [7:0] CMD_SET_ADDR = 8'h80;
   localparam logic [7:0] ROW1_BASE    = 8'h40;

   localparam kind_type KIND_SPARE_LO = 3'd5;
   localparam kind_type KIND_SPARE_HI = 3'd7;

   typedef struct {
      kind_type   kind;
      logic [7:0] byte_value;
      logic [5:0] column;
      logic       row;
   } lcd_request_type;

   typedef struct {
      logic       register_select;
      logic [7:0] bus_value;
      logic       strobe_res;
      logic [7:0] wait_ms;
      logic       last;
   } lcd_transfer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = '0;
   logic [7:0]  req_byte_value = '0;
   logic [5:0]  req_column = '0;
   logic        req_row = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_register_select;
   logic [7:0]  rsp_bus_value;
   logic        rsp_strobe_res;
   logic [7:0]  rsp_wait_ms;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lcd_request_type  lcd_requests[$];
   lcd_transfer_type lcd_xfers_due[$];
   logic          wide_bus = 1'b0;
   bit            burst_mode = 1'b0;
   int            mismatches = 0;
   int            req_gap = 0;
   int            rsp_stall = 0;
   int            idle_cycles = 0;

   char_lcd_bus_sequencer_unit #(
      .POWER_ON_WAIT_MS(POWER_ON_MS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_byte_value     (req_byte_value),
      .req_column         (req_column),
      .req_row            (req_row),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_register_select(rsp_register_select),
      .rsp_bus_value      (rsp_bus_value),
      .rsp_strobe_res     (rsp_strobe_res),
      .rsp_wait_ms        (rsp_wait_ms),
      .rsp_last           (rsp_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly back-to-back, some short gaps and the occasional long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic push_transfer(input logic rs, input logic [7:0] bus, input logic strobe,
                                input logic [7:0] wait_ms);
      lcd_transfer_type t;
      t.register_select = rs;
      t.bus_value       = bus;
      t.strobe_res      = strobe;
      t.wait_ms         = wait_ms;
      t.last            = 1'b0;
      lcd_xfers_due.push_back(t);
   endtask

   // On the narrow bus the high nibble always settles for the minimum time and the
   // low nibble carries the wait of the whole byte.
   task automatic push_byte(input logic rs, input logic [7:0] b, input logic [7:0] wait_ms);
      if (wide_bus) begin
         push_transfer(rs, b, 1'b1, wait_ms);
      end else begin
         push_transfer(rs, {4'h0, b[7:4]}, 1'b1, SETTLE_MS);
         push_transfer(rs, {4'h0, b[3:0]}, 1'b1, wait_ms);
      end
   endtask

   task automatic predict_transfers(input lcd_request_type q);
      lcd_transfer_type tail;
      int            first;
      first = lcd_xfers_due.size();
      case (q.kind)
         KIND_INIT: begin
            push_transfer(1'b0, 8'h00, 1'b0, 8'(POWER_ON_MS));
            if (wide_bus) begin
               repeat (3) push_transfer(1'b0, CMD_FUNC_8BIT, 1'b1, LONG_MS);
               push_byte(1'b0, CMD_FUNC_8BIT, SETTLE_MS);
            end else begin
               push_transfer(1'b0, WAKE_NIBBLE, 1'b1, LONG_MS);
               push_transfer(1'b0, WAKE_NIBBLE, 1'b1, LONG_MS);
               push_transfer(1'b0, WAKE_NIBBLE, 1'b1, SHORT_MS);
               push_transfer(1'b0, WAKE_4BIT, 1'b1, SHORT_MS);
               push_byte(1'b0, CMD_FUNC_4BIT, SETTLE_MS);
            end
            push_byte(1'b0, CMD_DISPLAY_ON, SHORT_MS);
            push_byte(1'b0, CMD_CLEAR, LONG_MS);
            push_byte(1'b0, CMD_ENTRY, SHORT_MS);
         end
         KIND_CMD:    push_byte(1'b0, q.byte_value, SETTLE_MS);
         KIND_DATA:   push_byte(1'b1, q.byte_value, SETTLE_MS);
         KIND_CLEAR:  push_byte(1'b0, CMD_CLEAR, LONG_MS);
         KIND_CURSOR: push_byte(1'b0, CMD_SET_ADDR | ((q.row ? ROW1_BASE : 8'h00) +
                                                      {2'b00, q.column}), SETTLE_MS);
         default: ;
      endcase
      if (lcd_xfers_due.size() > first) begin
         tail = lcd_xfers_due.pop_back();
         tail.last = 1'b1;
         lcd_xfers_due.push_back(tail);
      end
   endtask

   always @(posedge clock) begin : req_driver
      lcd_request_type nxt;
      lcd_request_type seen;
      logic         taken;
      taken = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (taken) begin
            seen.kind       = req_kind;
            seen.byte_value = req_byte_value;
            seen.column     = req_column;
            seen.row        = req_row;
            predict_transfers(seen);
         end
         if (!req_valid || taken) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (lcd_requests.size() > 0) begin
               nxt = lcd_requests.pop_front();
               req_valid      <= 1'b1;
               req_kind       <= nxt.kind;
               req_byte_value <= nxt.byte_value;
               req_column     <= nxt.column;
               req_row        <= nxt.row;
               req_gap = burst_mode ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = burst_mode ? 0 : pick_gap();
      end
   end

   task automatic check_field(input string name, input logic [7:0] expected,
                              input logic [7:0] actual);
      if (actual !== expected) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      lcd_transfer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lcd_xfers_due.size() == 0) begin
            $error("transfer arrived with no transaction waiting for it");
            mismatches++;
         end else begin
            want = lcd_xfers_due.pop_front();
            check_field("register_select", 8'(want.register_select), 8'(rsp_register_select));
            check_field("bus_value", want.bus_value, rsp_bus_value);
            check_field("strobe_res", 8'(want.strobe_res), 8'(rsp_strobe_res));
            check_field("wait_ms", want.wait_ms, rsp_wait_ms);
            check_field("last", 8'(want.last), 8'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   task automatic add_request(input kind_type kind, input logic [7:0] byte_value,
                              input logic [5:0] column, input logic row);
      lcd_request_type q;
      q.kind       = kind;
      q.byte_value = byte_value;
      q.column     = column;
      q.row        = row;
      lcd_requests.push_back(q);
   endtask

   // Unused kinds cause no transfer, so the settle time covers a request that may
   // still be in flight when the last expected transfer has come.
   task automatic wait_idle();
      while (lcd_requests.size() != 0 || req_valid || lcd_xfers_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bus_mode(input logic mode);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_EIGHT_BIT_BUS;
      csr_pwdata  <= {31'($urandom_range(0, 32'h7FFF_FFFF)), mode};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      wide_bus = mode;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[0] !== mode) begin
         $error("eight_bit_bus: expected %0d, actual %0d", mode, readback[0]);
         mismatches++;
      end
   endtask

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [5:0] rand_column();
      return 6'($urandom_range(0, 63));
   endfunction

   initial begin
      int       random_requests;
      int       phase_len;
      int       r;
      logic     mode;
      kind_type kind;

      random_requests = 0;
      mode = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_bus_mode(1'b0);
      add_request(KIND_INIT, rand_byte(), rand_column(), 1'($urandom_range(0, 1)));
      add_request(KIND_CMD, 8'h00, rand_column(), 1'b0);
      add_request(KIND_CMD, 8'hFF, rand_column(), 1'b1);
      add_request(KIND_DATA, 8'h00, rand_column(), 1'b0);
      add_request(KIND_DATA, 8'hFF, rand_column(), 1'b1);
      add_request(KIND_CLEAR, rand_byte(), rand_column(), 1'b0);
      add_request(KIND_CURSOR, rand_byte(), 6'd0, 1'b0);
      add_request(KIND_CURSOR, rand_byte(), 6'd63, 1'b1);
      add_request(KIND_SPARE_LO, rand_byte(), rand_column(), 1'b0);
      add_request(KIND_SPARE_HI, rand_byte(), rand_column(), 1'b1);
      wait_idle();

      write_bus_mode(1'b1);
      add_request(KIND_INIT, rand_byte(), rand_column(), 1'($urandom_range(0, 1)));
      add_request(KIND_CMD, 8'hFF, rand_column(), 1'b0);
      add_request(KIND_DATA, 8'h00, rand_column(), 1'b1);
      add_request(KIND_DATA, 8'hFF, rand_column(), 1'b0);
      add_request(KIND_CLEAR, rand_byte(), rand_column(), 1'b1);
      add_request(KIND_CURSOR, rand_byte(), 6'd0, 1'b1);
      add_request(KIND_CURSOR, rand_byte(), 6'd63, 1'b0);
      add_request(KIND_SPARE_LO + 3'd1, rand_byte(), rand_column(), 1'b0);
      wait_idle();

      // Random phases alternate the bus width; some run with no idling at all.
      while (random_requests < RANDOM_TARGET) begin
         write_bus_mode(mode);
         burst_mode = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(25, 45);
         for (int i = 0; i < phase_len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               kind = KIND_INIT;
            end else if (r < 92) begin
               kind = kind_type'($urandom_range(KIND_CMD, KIND_CURSOR));
            end else begin
               kind = kind_type'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            end
            add_request(kind, rand_byte(), rand_column(), 1'($urandom_range(0, 1)));
            random_requests++;
         end
         wait_idle();
         mode = !mode;
      end

      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
